// File: hdl/rrc_pkg.sv
// ----------------------------------------------------------------------------
// Rounded box coverage package
// Shared widths, register indexes and parameter defaults.
// ----------------------------------------------------------------------------
package rrc_pkg;

    localparam int DEF_MAX_FACTOR = 16;
    localparam int DEF_COORD_BITS = 12;

    localparam int CNT_W     = 9;
    localparam int FACTOR_W  = 5;
    localparam int CFG_IDX_W = 3;
    localparam int OUT_W     = 24;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS_TL     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS_TR     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS_BR     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS_BL     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_FACTOR = 3'd6;

endpackage

// File: hdl/rounded_rect_pixel_coverage_unit.sv
// ----------------------------------------------------------------------------
// Rounded box pixel coverage unit
// Counts the subsamples of a pixel inside and outside a box with rounded
// corners, both scaled by the sample factor.
// ----------------------------------------------------------------------------
// One item at a time through a single shared multiplier. First the box,
// radii and pixel position are scaled by F, the effective sample factor,
// one value per scale step. Each subsample then gets the box and corner
// square checks in the test state and, per corner curve tested, one
// multiply for dx*dy and one for the square of the curve slack, stopping at
// the first curve it lies beyond. The done state hands the result to the
// output register and the idle state takes the next item. The result waits
// in the output register, so the next item is taken while it is still
// unread; a later result waits in the core until that register has been
// read.
module rounded_rect_pixel_coverage_unit
    import rrc_pkg::*;
#(
    parameter int MAX_FACTOR = DEF_MAX_FACTOR,
    parameter int COORD_BITS = DEF_COORD_BITS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [COORD_BITS-1:0]     i_cfg_data,
    input  logic                      i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    // pixel_x, pixel_y
    input  logic [((2*(COORD_BITS+1)+7)/8)*8-1:0] i_s_axis_tdata,
    output logic                      o_m_axis_tvalid,
    input  logic                      i_m_axis_tready,
    // inside_count, outside_count
    output logic [OUT_W-1:0]          o_m_axis_tdata
);

    logic [COORD_BITS-1:0] r_frame_width;
    logic [COORD_BITS-1:0] r_frame_height;
    logic [COORD_BITS-1:0] r_radius_tl;
    logic [COORD_BITS-1:0] r_radius_tr;
    logic [COORD_BITS-1:0] r_radius_br;
    logic [COORD_BITS-1:0] r_radius_bl;
    logic [FACTOR_W-1:0]   r_sample_factor;

    logic                  r_out_valid;
    logic [CNT_W-1:0]      r_out_ins, r_out_outs;

    logic                  core_idle, res_valid, res_take, start;
    logic [CNT_W-1:0]      core_ins, core_outs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width   <= '0;
            r_frame_height  <= '0;
            r_radius_tl     <= '0;
            r_radius_tr     <= '0;
            r_radius_br     <= '0;
            r_radius_bl     <= '0;
            r_sample_factor <= FACTOR_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_FRAME_WIDTH:   r_frame_width   <= i_cfg_data;
                REG_FRAME_HEIGHT:  r_frame_height  <= i_cfg_data;
                REG_RADIUS_TL:     r_radius_tl     <= i_cfg_data;
                REG_RADIUS_TR:     r_radius_tr     <= i_cfg_data;
                REG_RADIUS_BR:     r_radius_br     <= i_cfg_data;
                REG_RADIUS_BL:     r_radius_bl     <= i_cfg_data;
                REG_SAMPLE_FACTOR: r_sample_factor <= i_cfg_data[FACTOR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign start    = i_s_axis_tvalid && core_idle;
    assign res_take = res_valid && (!r_out_valid || i_m_axis_tready);

    rrc_core #(
        .MAX_FACTOR (MAX_FACTOR),
        .COORD_BITS (COORD_BITS)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_px       (i_s_axis_tdata[COORD_BITS:0]),
        .i_py       (i_s_axis_tdata[2*COORD_BITS+1:COORD_BITS+1]),
        .i_width    (r_frame_width),
        .i_height   (r_frame_height),
        .i_rad_tl   (r_radius_tl),
        .i_rad_tr   (r_radius_tr),
        .i_rad_br   (r_radius_br),
        .i_rad_bl   (r_radius_bl),
        .i_factor   (r_sample_factor),
        .i_res_take (res_take),
        .o_idle     (core_idle),
        .o_res_valid(res_valid),
        .o_ins      (core_ins),
        .o_outs     (core_outs)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out_ins  <= core_ins;
            r_out_outs <= core_outs;
        end
    end

    assign o_s_axis_tready = core_idle;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(OUT_W-2*CNT_W){1'b0}}, r_out_outs, r_out_ins};

endmodule

// File: hdl/rrc_core.sv
// ----------------------------------------------------------------------------
// Rounded box coverage sequencer
// Scales the box, then walks the subsamples with one shared multiplier.
// ----------------------------------------------------------------------------
module rrc_core
    import rrc_pkg::*;
#(
    parameter int MAX_FACTOR = DEF_MAX_FACTOR,
    parameter int COORD_BITS = DEF_COORD_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [COORD_BITS:0]   i_px,
    input  logic [COORD_BITS:0]   i_py,
    input  logic [COORD_BITS-1:0] i_width,
    input  logic [COORD_BITS-1:0] i_height,
    input  logic [COORD_BITS-1:0] i_rad_tl,
    input  logic [COORD_BITS-1:0] i_rad_tr,
    input  logic [COORD_BITS-1:0] i_rad_br,
    input  logic [COORD_BITS-1:0] i_rad_bl,
    input  logic [FACTOR_W-1:0]   i_factor,
    input  logic                  i_res_take,
    output logic                  o_idle,
    output logic                  o_res_valid,
    output logic [CNT_W-1:0]      o_ins,
    output logic [CNT_W-1:0]      o_outs
);

    localparam int FB = $clog2(MAX_FACTOR + 1);
    localparam int SW = COORD_BITS + FB;
    localparam int CW = SW + 2;
    localparam int PW = 2 * CW;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCALE = 3'd1;
    localparam logic [2:0] ST_TEST  = 3'd2;
    localparam logic [2:0] ST_MULA  = 3'd3;
    localparam logic [2:0] ST_MULB  = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0]           r_state, n_state;
    logic [2:0]           r_k;
    logic [FB-1:0]        r_f, n_f;
    logic [COORD_BITS:0]  r_px, r_py;
    logic [SW-1:0]        r_w, r_h;
    logic [SW-1:0]        r_rad [4];
    logic signed [CW-1:0] r_bx, r_sx, r_sy;
    logic [FB-1:0]        r_i, r_j;
    logic [SW-1:0]        r_dl, r_dr, r_dt, r_db;
    logic [3:0]           r_cmask;
    logic signed [CW-1:0] r_d;
    logic [PW-1:0]        r_p4;
    logic [CNT_W-1:0]     r_ins, r_outs;

    logic signed [CW-1:0] mul_a, mul_b;
    logic signed [PW-1:0] mul_p;
    logic [COORD_BITS-1:0] cfg_val;

    logic signed [CW-1:0] w_s, h_s, dr_s, db_s;
    logic                 box_out;
    logic [3:0]           cmask;
    logic [SW-1:0]        sel_dx, sel_dy, sel_r;
    logic signed [CW-1:0] d_s;
    logic [3:0]           mask_next;
    logic                 beyond;
    logic                 adv, adv_out, last_i, last_j;

    // effective factor: zero acts as one, large values saturate
    always_comb begin
        if (i_factor == '0) begin
            n_f = FB'(1);
        end else if (32'(i_factor) > MAX_FACTOR) begin
            n_f = FB'(MAX_FACTOR);
        end else begin
            n_f = FB'(i_factor);
        end
    end

    always_comb begin
        case (r_k)
            3'd0:    cfg_val = i_width;
            3'd1:    cfg_val = i_height;
            3'd2:    cfg_val = i_rad_tl;
            3'd3:    cfg_val = i_rad_tr;
            3'd4:    cfg_val = i_rad_br;
            3'd5:    cfg_val = i_rad_bl;
            default: cfg_val = '0;
        endcase
    end

    // box test and corner square membership
    always_comb begin
        w_s     = $signed({{(CW-SW){1'b0}}, r_w});
        h_s     = $signed({{(CW-SW){1'b0}}, r_h});
        dr_s    = w_s - CW'(1) - r_sx;
        db_s    = h_s - CW'(1) - r_sy;
        box_out = (r_sx < 0) || (r_sy < 0) || (r_sx >= w_s) || (r_sy >= h_s);
        cmask[0] = (r_rad[0] != '0) && (SW'(r_sx) < r_rad[0]) && (SW'(r_sy) < r_rad[0]);
        cmask[1] = (r_rad[1] != '0) && (SW'(dr_s) < r_rad[1]) && (SW'(r_sy) < r_rad[1]);
        cmask[2] = (r_rad[2] != '0) && (SW'(dr_s) < r_rad[2]) && (SW'(db_s) < r_rad[2]);
        cmask[3] = (r_rad[3] != '0) && (SW'(r_sx) < r_rad[3]) && (SW'(db_s) < r_rad[3]);
    end

    // lowest pending corner
    always_comb begin
        if (r_cmask[0]) begin
            sel_dx = r_dl; sel_dy = r_dt; sel_r = r_rad[0];
        end else if (r_cmask[1]) begin
            sel_dx = r_dr; sel_dy = r_dt; sel_r = r_rad[1];
        end else if (r_cmask[2]) begin
            sel_dx = r_dr; sel_dy = r_db; sel_r = r_rad[2];
        end else begin
            sel_dx = r_dl; sel_dy = r_db; sel_r = r_rad[3];
        end
        d_s = $signed({{(CW-SW){1'b0}}, sel_r}) - $signed({{(CW-SW){1'b0}}, sel_dx})
            - $signed({{(CW-SW){1'b0}}, sel_dy});
        mask_next = r_cmask & (r_cmask - 4'd1);
    end

    // shared multiplier
    always_comb begin
        case (r_state)
            ST_SCALE: begin
                if (r_k == 3'd6) begin
                    mul_a = $signed({{(CW-COORD_BITS-1){r_px[COORD_BITS]}}, r_px});
                end else if (r_k == 3'd7) begin
                    mul_a = $signed({{(CW-COORD_BITS-1){r_py[COORD_BITS]}}, r_py});
                end else begin
                    mul_a = $signed({{(CW-COORD_BITS){1'b0}}, cfg_val});
                end
                mul_b = $signed({{(CW-FB){1'b0}}, r_f});
            end
            ST_MULA: begin
                mul_a = $signed({{(CW-SW){1'b0}}, sel_dx});
                mul_b = $signed({{(CW-SW){1'b0}}, sel_dy});
            end
            ST_MULB: begin
                mul_a = r_d;
                mul_b = r_d;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    assign beyond = !r_d[CW-1] && (r_p4 <= $unsigned(mul_p));
    assign last_i = (r_i == r_f - FB'(1));
    assign last_j = (r_j == r_f - FB'(1));

    always_comb begin
        n_state = r_state;
        adv     = 1'b0;
        adv_out = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_SCALE;
                end
            end
            ST_SCALE: begin
                if (r_k == 3'd7) begin
                    n_state = ST_TEST;
                end
            end
            ST_TEST: begin
                if (box_out) begin
                    adv     = 1'b1;
                    adv_out = 1'b1;
                end else if (cmask == 4'd0) begin
                    adv = 1'b1;
                end else begin
                    n_state = ST_MULA;
                end
            end
            ST_MULA: begin
                n_state = ST_MULB;
            end
            ST_MULB: begin
                if (beyond) begin
                    adv     = 1'b1;
                    adv_out = 1'b1;
                end else if (mask_next == 4'd0) begin
                    adv = 1'b1;
                end else begin
                    n_state = ST_MULA;
                end
            end
            ST_DONE: begin
                if (i_res_take) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
        if (adv) begin
            n_state = (last_i && last_j) ? ST_DONE : ST_TEST;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_k    <= 3'd0;
                r_f    <= n_f;
                r_px   <= i_px;
                r_py   <= i_py;
                r_i    <= '0;
                r_j    <= '0;
                r_ins  <= '0;
                r_outs <= '0;
            end
            ST_SCALE: begin
                r_k <= r_k + 3'd1;
                case (r_k)
                    3'd0:    r_w <= SW'(mul_p);
                    3'd1:    r_h <= SW'(mul_p);
                    3'd2:    r_rad[0] <= SW'(mul_p);
                    3'd3:    r_rad[1] <= SW'(mul_p);
                    3'd4:    r_rad[2] <= SW'(mul_p);
                    3'd5:    r_rad[3] <= SW'(mul_p);
                    3'd6: begin
                        r_bx <= CW'(mul_p);
                        r_sx <= CW'(mul_p);
                    end
                    default: r_sy <= CW'(mul_p);
                endcase
            end
            ST_TEST: begin
                r_dl    <= SW'(r_sx);
                r_dr    <= SW'(dr_s);
                r_dt    <= SW'(r_sy);
                r_db    <= SW'(db_s);
                r_cmask <= cmask;
            end
            ST_MULA: begin
                r_p4 <= PW'({mul_p, 2'b00});
                r_d  <= d_s;
            end
            ST_MULB: begin
                r_cmask <= mask_next;
            end
            default: begin
            end
        endcase
        if (adv) begin
            if (adv_out) begin
                r_outs <= r_outs + CNT_W'(1);
            end else begin
                r_ins <= r_ins + CNT_W'(1);
            end
            if (last_i) begin
                r_i  <= '0;
                r_j  <= r_j + FB'(1);
                r_sx <= r_bx;
                r_sy <= r_sy + CW'(1);
            end else begin
                r_i  <= r_i + FB'(1);
                r_sx <= r_sx + CW'(1);
            end
        end
    end

    assign o_idle      = (r_state == ST_IDLE);
    assign o_res_valid = (r_state == ST_DONE);
    assign o_ins       = r_ins;
    assign o_outs      = r_outs;

    a_count_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) |->
        ({1'b0, r_ins} + {1'b0, r_outs}) == (CNT_W+1)'(r_f * r_f))
        else $error("subsample counts do not add up to factor squared");

    a_corner_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MULA || r_state == ST_MULB) |-> (r_cmask != 4'd0))
        else $error("curve test without a pending corner");

    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_TEST) |-> (r_i < r_f) && (r_j < r_f))
        else $error("subsample index beyond factor");

    a_start_scale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && i_start) |=> (r_state == ST_SCALE))
        else $error("accepted item did not start scaling");

endmodule

// File: verif/rrc_coverage_checker.sv
// ----------------------------------------------------------------------------
// Rounded box coverage checker
// Watches the register port and both streams. It keeps its own copy of the
// box registers, predicts the inside and outside subsample counts of every
// accepted pixel, and compares each returned item against the oldest
// prediction.
// ----------------------------------------------------------------------------
module rrc_coverage_checker
    import rrc_pkg::*;
#(
    parameter int MAX_FACTOR = DEF_MAX_FACTOR,
    parameter int COORD_BITS = DEF_COORD_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [COORD_BITS-1:0] i_cfg_data,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    // pixel_x, pixel_y
    input  logic [((2*(COORD_BITS+1)+7)/8)*8-1:0] i_s_tdata,
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    // inside_count, outside_count
    input  logic [OUT_W-1:0]      i_m_tdata,
    output int                    o_errors,
    output int                    o_pending,
    output int                    o_checked
);

    localparam int PIX_W = COORD_BITS + 1;

    typedef struct packed {
        logic [CNT_W-1:0] out_count;
        logic [CNT_W-1:0] in_count;
    } t_counts;

    logic [COORD_BITS-1:0] box_w  = '0;
    logic [COORD_BITS-1:0] box_h  = '0;
    logic [COORD_BITS-1:0] rad_tl = '0;
    logic [COORD_BITS-1:0] rad_tr = '0;
    logic [COORD_BITS-1:0] rad_br = '0;
    logic [COORD_BITS-1:0] rad_bl = '0;
    logic [FACTOR_W-1:0]   factor = FACTOR_W'(1);
    t_counts               expected_counts [$];
    int                    errors  = 0;
    int                    checked = 0;

    // true when the subsample sits in the corner square and on or past the curve
    function automatic bit cut_by_corner(longint dx, longint dy, longint r);
        longint slack;
        slack = r - dx - dy;
        if (r == 0 || dx >= r || dy >= r || slack < 0)
            return 1'b0;
        return 4 * dx * dy <= slack * slack;
    endfunction

    function automatic t_counts count_coverage(logic signed [PIX_W-1:0] px,
                                               logic signed [PIX_W-1:0] py);
        longint  f, w, h, tl, tr, br, bl, sx, sy;
        int      ins, outs;
        bit      hit;
        t_counts c;
        f = longint'(factor);
        if (f < 1)
            f = 1;
        if (f > MAX_FACTOR)
            f = MAX_FACTOR;
        w  = longint'(box_w) * f;
        h  = longint'(box_h) * f;
        tl = longint'(rad_tl) * f;
        tr = longint'(rad_tr) * f;
        br = longint'(rad_br) * f;
        bl = longint'(rad_bl) * f;
        ins  = 0;
        outs = 0;
        for (longint j = 0; j < f; j++) begin
            for (longint i = 0; i < f; i++) begin
                sx  = longint'(px) * f + i;
                sy  = longint'(py) * f + j;
                hit = sx >= 0 && sy >= 0 && sx < w && sy < h
                    && !cut_by_corner(sx, sy, tl)
                    && !cut_by_corner(w - 1 - sx, sy, tr)
                    && !cut_by_corner(w - 1 - sx, h - 1 - sy, br)
                    && !cut_by_corner(sx, h - 1 - sy, bl);
                if (hit)
                    ins++;
                else
                    outs++;
            end
        end
        c.in_count  = CNT_W'(ins);
        c.out_count = CNT_W'(outs);
        return c;
    endfunction

    always @(posedge i_clk) begin
        t_counts got;
        t_counts want;
        if (!i_rst_n) begin
            box_w  = '0;
            box_h  = '0;
            rad_tl = '0;
            rad_tr = '0;
            rad_br = '0;
            rad_bl = '0;
            factor = FACTOR_W'(1);
            expected_counts.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got = t_counts'(i_m_tdata[2*CNT_W-1:0]);
                if (expected_counts.size() == 0) begin
                    $display("%0t: unexpected item, inside %0d outside %0d", $time,
                             got.in_count, got.out_count);
                    errors++;
                end else begin
                    want = expected_counts.pop_front();
                    if (got.in_count !== want.in_count) begin
                        $display("%0t: inside count expected %0d, got %0d", $time,
                                 want.in_count, got.in_count);
                        errors++;
                    end
                    if (got.out_count !== want.out_count) begin
                        $display("%0t: outside count expected %0d, got %0d", $time,
                                 want.out_count, got.out_count);
                        errors++;
                    end
                    checked++;
                end
            end
            if (i_s_tvalid && i_s_tready)
                expected_counts.push_back(count_coverage(i_s_tdata[PIX_W-1:0],
                                                         i_s_tdata[2*PIX_W-1:PIX_W]));
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_FRAME_WIDTH:   box_w  = i_cfg_data;
                    REG_FRAME_HEIGHT:  box_h  = i_cfg_data;
                    REG_RADIUS_TL:     rad_tl = i_cfg_data;
                    REG_RADIUS_TR:     rad_tr = i_cfg_data;
                    REG_RADIUS_BR:     rad_br = i_cfg_data;
                    REG_RADIUS_BL:     rad_bl = i_cfg_data;
                    REG_SAMPLE_FACTOR: factor = i_cfg_data[FACTOR_W-1:0];
                    default: ;
                endcase
            end
        end
        o_errors  <= errors;
        o_pending <= expected_counts.size();
        o_checked <= checked;
    end

endmodule

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// Rounded box pixel coverage unit testbench
// Programs a series of box shapes and sample factors, streams pixels near the
// box edges and corners plus random positions over the whole coordinate
// range, with random gaps on the input and stalls on the output. Results are
// checked by the coverage checker instantiated alongside the unit.
// ----------------------------------------------------------------------------
module tb_top;
    import rrc_pkg::*;

    localparam int COORD_BITS    = DEF_COORD_BITS;
    localparam int PIX_W         = COORD_BITS + 1;
    localparam int IN_W          = ((2 * PIX_W + 7) / 8) * 8;
    localparam int RANDOM_PIXELS = 1900;
    localparam int QUIET_LIMIT   = 20000;
    localparam int DRAIN_CYCLES  = 64;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
    logic [COORD_BITS-1:0] cfg_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_W-1:0]       s_tdata  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_W-1:0]      m_tdata;
    int                    errors;
    int                    pending;
    int                    checked;
    bit                    tx_gaps   = 1'b1;
    bit                    rx_stalls = 1'b1;
    int                    quiet     = 0;
    int                    settings  = 0;
    int                    shape_w, shape_h, shape_r, shape_f;

    rounded_rect_pixel_coverage_unit u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    rrc_coverage_checker u_checker (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_s_tvalid (s_tvalid),
        .i_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .i_m_tdata  (m_tdata),
        .o_errors   (errors),
        .o_pending  (pending),
        .o_checked  (checked)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // mostly short, now and then long
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return int'($urandom_range(1, 3));
        if (r < 95)
            return int'($urandom_range(4, 12));
        return int'($urandom_range(30, 80));
    endfunction

    function automatic int pick_extent();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return int'($urandom_range(0, 40));
        if (r < 90)
            return int'($urandom_range(41, 300));
        return int'($urandom_range(0, 4095));
    endfunction

    initial begin
        int hold;
        hold = 0;
        forever begin
            @(posedge clk);
            if (hold > 0) begin
                hold--;
            end else if (!rx_stalls || $urandom_range(0, 1) == 0) begin
                m_tready <= 1'b1;
                hold = rx_stalls ? int'($urandom_range(0, 6)) : 0;
            end else begin
                m_tready <= 1'b0;
                hold = idle_length() - 1;
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("rounded_rect_pixel_coverage_unit test failed");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [COORD_BITS-1:0] value);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic load_shape(input int w, input int h, input int tl, input int tr,
                              input int br, input int bl, input int f);
        int eff;
        drain();
        set_reg(REG_FRAME_WIDTH,   COORD_BITS'(w));
        set_reg(REG_FRAME_HEIGHT,  COORD_BITS'(h));
        set_reg(REG_RADIUS_TL,     COORD_BITS'(tl));
        set_reg(REG_RADIUS_TR,     COORD_BITS'(tr));
        set_reg(REG_RADIUS_BR,     COORD_BITS'(br));
        set_reg(REG_RADIUS_BL,     COORD_BITS'(bl));
        set_reg(REG_SAMPLE_FACTOR, COORD_BITS'(f));
        eff = f & 31;
        if (eff == 0)
            eff = 1;
        if (eff > DEF_MAX_FACTOR)
            eff = DEF_MAX_FACTOR;
        shape_w = w & 4095;
        shape_h = h & 4095;
        shape_r = tl;
        if (tr > shape_r) shape_r = tr;
        if (br > shape_r) shape_r = br;
        if (bl > shape_r) shape_r = bl;
        shape_f = eff;
        settings++;
    endtask

    task automatic send_pixel(input int x, input int y);
        int gap;
        gap = (tx_gaps && $urandom_range(0, 2) == 0) ? idle_length() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_W'({y[PIX_W-1:0], x[PIX_W-1:0]});
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic send_random_pixel();
        int r, x, y, span;
        r    = $urandom_range(0, 99);
        span = (shape_r < 3) ? 3 : shape_r + 2;
        if (r < 60) begin
            x = int'($urandom_range(0, shape_w + 3)) - 2;
            y = int'($urandom_range(0, shape_h + 3)) - 2;
        end else if (r < 80) begin
            x = $urandom_range(0, 1) ? int'($urandom_range(0, span)) - 1
                                     : shape_w - int'($urandom_range(0, span));
            y = $urandom_range(0, 1) ? int'($urandom_range(0, span)) - 1
                                     : shape_h - int'($urandom_range(0, span));
        end else begin
            x = int'($urandom_range(0, 8191)) - 4096;
            y = int'($urandom_range(0, 8191)) - 4096;
        end
        send_pixel(x, y);
    endtask

    task automatic load_random_shape();
        int r, w, h, f, lim, big;
        int rad [4];
        r = $urandom_range(0, 99);
        if (r < 45)
            f = $urandom_range(1, 4);
        else if (r < 80)
            f = $urandom_range(5, 8);
        else if (r < 92)
            f = $urandom_range(9, 16);
        else
            f = $urandom_range(0, 4095);
        w   = pick_extent();
        h   = pick_extent();
        lim = (w < h ? w : h) / 2 + 1;
        big = (w > h ? w : h) + 2;
        if (big > 4095)
            big = 4095;
        foreach (rad[k]) begin
            r = $urandom_range(0, 99);
            if (r < 20)
                rad[k] = 0;
            else if (r < 80)
                rad[k] = $urandom_range(0, lim);
            else if (r < 95)
                rad[k] = $urandom_range(0, big);
            else
                rad[k] = $urandom_range(0, 4095);
        end
        load_shape(w, h, rad[0], rad[1], rad[2], rad[3], f);
    endtask

    initial begin
        int random_sent;
        int n;
        random_sent = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // registers at reset: empty box
        send_pixel(0, 0);
        send_pixel(-4096, 4095);

        load_shape(20, 12, 4, 0, 6, 3, 4);
        send_pixel(0, 0);
        send_pixel(1, 1);
        send_pixel(19, 0);
        send_pixel(19, 11);
        send_pixel(18, 10);
        send_pixel(0, 11);
        send_pixel(-1, 5);
        send_pixel(20, 5);
        send_pixel(7, -1);
        send_pixel(7, 12);
        send_pixel(10, 6);
        send_pixel(-4096, -4096);
        send_pixel(4095, 4095);
        send_pixel(4095, -4096);

        // factor zero acts as one
        load_shape(6, 5, 2, 2, 2, 2, 0);
        send_pixel(0, 0);

        // factor beyond the maximum saturates
        load_shape(3, 3, 1, 1, 1, 1, 4095);
        send_pixel(0, 0);
        send_pixel(2, 2);

        // write to an index past the register list changes nothing
        drain();
        set_reg(REG_UNUSED, '1);
        send_pixel(1, 1);

        // corner squares overlapping
        load_shape(10, 6, 8, 8, 8, 8, 2);
        send_pixel(0, 0);
        send_pixel(5, 3);

        // zero width, then zero height
        load_shape(0, 9, 0, 0, 0, 0, 2);
        send_pixel(0, 0);
        load_shape(9, 0, 0, 0, 0, 0, 2);
        send_pixel(0, 0);

        // largest box, radii and factor
        load_shape(4095, 4095, 4095, 4095, 4095, 4095, 16);
        send_pixel(0, 0);
        send_pixel(2047, 2047);
        send_pixel(4094, 4094);

        while (random_sent < RANDOM_PIXELS) begin
            load_random_shape();
            tx_gaps   = $urandom_range(0, 3) != 0;
            rx_stalls = $urandom_range(0, 3) != 0;
            if (shape_f > 8)
                n = 6;
            else if (shape_f > 4)
                n = $urandom_range(15, 40);
            else
                n = $urandom_range(20, 60);
            repeat (n) send_random_pixel();
            random_sent += n;
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Checked %0d pixels over %0d box settings: factors zero to saturated,",
                 checked, settings);
        $display("empty, overlapping and full-size boxes, unused register index.");
        if (errors == 0 && pending == 0)
            $display("rounded_rect_pixel_coverage_unit test passed");
        else
            $display("rounded_rect_pixel_coverage_unit test failed");
        $finish;
    end

endmodule
